[hw/rtl/bhwlsu_pkg.sv]
package bhwlsu_pkg;

  // Access modes as carried on in_tuser
  localparam logic [2:0] MODE_LB = 3'd0;
  localparam logic [2:0] MODE_LH = 3'd1;
  localparam logic [2:0] MODE_LW = 3'd2;
  localparam logic [2:0] MODE_SB = 3'd3;
  localparam logic [2:0] MODE_SH = 3'd4;
  localparam logic [2:0] MODE_SW = 3'd5;

  // Status codes as carried on out_tuser
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  localparam int DEF_MEM_WORDS = 256;
  // Widest word index the store can need (65536 words)
  localparam int MAX_IDX_W     = 16;
  localparam int QDEPTH        = 2;

  // One classified access, as handed from the front to the back
  typedef struct packed {
    logic                 access;     // valid mode, aligned and in range
    logic                 is_store;
    logic [1:0]           size;
    logic [1:0]           status;
    logic [1:0]           lane;
    logic [MAX_IDX_W-1:0] index;
    logic [31:0]          store_data;
  } lsu_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/bhwlsu_front.sv]
module bhwlsu_front
  import bhwlsu_pkg::*;
#(
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        back_ready,
  input  q_status_t   q_stat,
  output logic        push,
  output lsu_entry_t  push_entry
);

  localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [32:0] MEM_BYTES = 33'(4 * MEM_WORDS);

  logic [31:0] base_address;
  logic [15:0] displacement;
  logic [31:0] store_data;
  logic [32:0] ea;
  logic        mode_ok;
  logic        is_store;
  logic [1:0]  size;
  logic        misaligned;
  logic        beyond;
  logic [1:0]  status;

  assign base_address = in_tdata[31:0];
  assign displacement = in_tdata[47:32];
  assign store_data   = in_tdata[79:48];

  assign ea = {1'b0, base_address} + {17'b0, displacement};

  always_comb begin
    mode_ok  = 1'b1;
    is_store = 1'b0;
    size     = SZ_BYTE;
    case (in_tuser)
      MODE_LB: size = SZ_BYTE;
      MODE_LH: size = SZ_HALF;
      MODE_LW: size = SZ_WORD;
      MODE_SB: begin
        size     = SZ_BYTE;
        is_store = 1'b1;
      end
      MODE_SH: begin
        size     = SZ_HALF;
        is_store = 1'b1;
      end
      MODE_SW: begin
        size     = SZ_WORD;
        is_store = 1'b1;
      end
      default: mode_ok = 1'b0;
    endcase
  end

  assign misaligned = ((size == SZ_HALF) && ea[0]) ||
                      ((size == SZ_WORD) && (ea[1:0] != 2'b00));
  assign beyond     = (ea >= MEM_BYTES);

  always_comb begin
    status = ST_OK;
    if (mode_ok) begin
      if (misaligned) begin
        status = ST_MISALIGNED;
      end else if (beyond) begin
        status = ST_RANGE;
      end
    end
  end

  assign in_tready = back_ready && !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_entry.access     = mode_ok && (status == ST_OK);
    push_entry.is_store   = is_store && mode_ok;
    push_entry.size       = size;
    push_entry.status     = status;
    push_entry.lane       = ea[1:0];
    push_entry.index      = MAX_IDX_W'(ea[IDX_W+1:2]);
    push_entry.store_data = store_data;
  end

  // Pushes never land while the store is still being cleared
  a_no_push_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !back_ready |-> !push)
    else $error("item taken during clearing pass");

endmodule

[hw/rtl/bhwlsu_queue.sv]
module bhwlsu_queue
  import bhwlsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lsu_entry_t push_entry,
  input  logic       pop,
  output lsu_entry_t head,
  output q_status_t  q_stat
);

  lsu_entry_t  entries_r [QDEPTH];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        do_push;
  logic        do_pop;

  assign q_stat.full  = (count_r == 2'(QDEPTH));
  assign q_stat.empty = (count_r == 2'd0);
  assign head         = entries_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QDEPTH))
    else $error("queue count past depth");

endmodule

[hw/rtl/bhwlsu_back.sv]
module bhwlsu_back
  import bhwlsu_pkg::*;
#(
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   q_stat,
  input  lsu_entry_t  head,
  output logic        pop,
  output logic        back_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [31:0]      mem [MEM_WORDS];
  logic [31:0]      rdata_r;
  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [IDX_W-1:0] clr_idx_r;
  logic [IDX_W-1:0] clr_idx_nxt;
  lsu_entry_t       cur_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [31:0]      out_data_r;
  logic [1:0]       out_status_r;
  logic             commit;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic [4:0]       shamt;
  logic [31:0]      lane_word;
  logic [31:0]      size_mask;
  logic [31:0]      lane_mask;
  logic [31:0]      merged;
  logic [31:0]      load_val;

  assign back_ready = (state_r != S_CLEAR);
  assign pop        = (state_r == S_IDLE) && !q_stat.empty;
  assign commit     = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign shamt     = {cur_r.lane, 3'b000};
  assign lane_word = rdata_r >> shamt;

  always_comb begin
    case (cur_r.size)
      SZ_BYTE: size_mask = BYTE_MASK;
      SZ_HALF: size_mask = HALF_MASK;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  end

  assign lane_mask = size_mask << shamt;
  assign merged    = (rdata_r & ~lane_mask) | ((cur_r.store_data & size_mask) << shamt);

  always_comb begin
    case (cur_r.size)
      SZ_BYTE: load_val = {{24{lane_word[7]}}, lane_word[7:0]};
      SZ_HALF: load_val = {{16{lane_word[15]}}, lane_word[15:0]};
      default: load_val = rdata_r;
    endcase
  end

  // Single write port: the clearing pass owns it until it is done
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = commit && cur_r.access && cur_r.is_store;
      mem_waddr = cur_r.index[IDX_W-1:0];
      mem_wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rdata_r <= mem[head.index[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          out_valid_nxt = out_valid_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (commit) begin
      out_data_r   <= (cur_r.access && !cur_r.is_store) ? load_val : 32'd0;
      out_status_r <= cur_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_no_result_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result shown during clearing pass");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed access did not reach output");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (cur_r.is_store || !cur_r.access)) |=> (out_data_r == 32'd0))
    else $error("store or failed access gave nonzero data");

  a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (cur_r.status != ST_OK)) |-> !mem_we)
    else $error("failed access wrote memory");

endmodule

[hw/rtl/byte_half_word_load_store_unit.sv]
// Byte / halfword / word load-store unit over an internal word store.
//
// Input channel (in_*): one word per memory access. in_tuser carries the
// mode (load byte/half/word, store byte/half/word); in_tdata carries the
// base address, the unsigned displacement and the store data.
// Result channel (out_*): one word per access, in order: the sign-extended
// load data (zero for stores and failed accesses) and a status code
// (ok, misaligned, address beyond memory).
//
// The front stage forms the effective address, checks alignment and range
// and pushes the classified access into a two-entry queue. The back stage
// pops it and registers the addressed word, then, once the output register
// is free, loads or merges the lane, writes back and registers the result.
// The back stage takes one access at a time: it pops the next only after
// the last has written its result to the output register.
//
// After reset the store is cleared one word a cycle, with in_tready low. A
// stalled receiver holds the output register; the queue keeps taking words
// until it is full, then in_tready drops.
module byte_half_word_load_store_unit
  import bhwlsu_pkg::*;
#(
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // base_address[31:0], displacement[47:32], store_data[79:48]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // load_data[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  q_status_t  q_stat;
  lsu_entry_t push_entry;
  lsu_entry_t head;
  logic       push;
  logic       pop;
  logic       back_ready;

  // Classify: address add, alignment and range check
  bhwlsu_front #(
    .MEM_WORDS (MEM_WORDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .back_ready (back_ready),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple front from back
  bhwlsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Execute against the word store, hold the result until taken
  bhwlsu_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .back_ready (back_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
